>>> hdl/sliding_trimmed_mean_filter_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sliding trimmed mean filter
// Clocked on clk, switched off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef SLIDING_TRIMMED_MEAN_FILTER_CORE_ASSERT_SVH
`define SLIDING_TRIMMED_MEAN_FILTER_CORE_ASSERT_SVH

// Same-cycle implication
`define STMF_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define STMF_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/stmf_pkg.sv
// ----------------------------------------------------------------------------
// stmf_pkg
// Shared constants and types of the sliding trimmed mean filter.
// ----------------------------------------------------------------------------
`default_nettype none

package stmf_pkg;

	// Default window depth
	localparam int WINDOW_LEN_DEF = 24;

	// Field widths
	localparam int SAMPLE_W = 24;
	localparam int OUT_W    = 28;
	localparam int FRAC_W   = 4;

	// Largest mean that can come out: full-scale sample with 4 fraction bits
	localparam logic [OUT_W-1:0] OUT_MAX = OUT_W'(((1 << SAMPLE_W) - 1) << FRAC_W);

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUM,
		ST_LAUNCH,
		ST_DIV,
		ST_HOLD
	} stmf_state_t;

endpackage

`default_nettype wire

>>> hdl/stmf_cell.sv
// ----------------------------------------------------------------------------
// stmf_cell
// One slot of the sorted window: a sample and its age. On each new sample
// the chain drops the oldest entry and opens a gap for the new one, every
// cell choosing between its own value, a neighbour's value and the sample.
// ----------------------------------------------------------------------------
`default_nettype none

module stmf_cell #(
	parameter int VAL_W     = 24,
	parameter int AGE_W     = 5,
	parameter int OLDEST    = 23,
	parameter int RESET_AGE = 0
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             load,
	input  wire logic [VAL_W-1:0] sample,
	input  wire logic [VAL_W-1:0] left_val,
	input  wire logic [AGE_W-1:0] left_age,
	input  wire logic             left_gt,
	input  wire logic [VAL_W-1:0] right_val,
	input  wire logic [AGE_W-1:0] right_age,
	input  wire logic             right_gt,
	input  wire logic             below_in,
	output logic                  below_out,
	output logic      [VAL_W-1:0] val,
	output logic      [AGE_W-1:0] age,
	output logic                  gt
);

	logic [VAL_W-1:0] val_q;
	logic [AGE_W-1:0] age_q;
	logic             old;
	logic [VAL_W-1:0] self_val, prev_val, nxt_val;
	logic [AGE_W-1:0] self_age, prev_age, nxt_age;
	logic             self_gt, prev_gt;

	assign val = val_q;
	assign age = age_q;
	assign gt  = val_q > sample;
	assign old = age_q == AGE_W'(OLDEST);

	// oldest entry at or below this slot
	assign below_out = below_in | old;

	// compacted window (oldest removed): entry at this slot and the one before
	always_comb begin
		self_val = below_out ? right_val : val_q;
		self_age = below_out ? right_age : age_q;
		self_gt  = below_out ? right_gt  : gt;
		prev_val = below_in  ? val_q     : left_val;
		prev_age = below_in  ? age_q     : left_age;
		prev_gt  = below_in  ? gt        : left_gt;
	end

	// keep, shift up from below, or take the new sample
	always_comb begin
		if (!self_gt) begin
			nxt_val = self_val;
			nxt_age = self_age + AGE_W'(1);
		end else if (prev_gt) begin
			nxt_val = prev_val;
			nxt_age = prev_age + AGE_W'(1);
		end else begin
			nxt_val = sample;
			nxt_age = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q <= '0;
			age_q <= AGE_W'(RESET_AGE);
		end else if (load) begin
			val_q <= nxt_val;
			age_q <= nxt_age;
		end
	end

endmodule

`default_nettype wire

>>> hdl/stmf_divider.sv
// ----------------------------------------------------------------------------
// stmf_divider
// Division by a fixed divisor through a multiply by its rounded-up reciprocal.
// The quotient is ready in the cycle after start and holds until the next start.
// ----------------------------------------------------------------------------
`default_nettype none

module stmf_divider #(
	parameter int NUM_W   = 31,
	parameter int DIVISOR = 6
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] numer,
	output logic                  done,
	output logic      [NUM_W-1:0] quot
);

	// floor(n / d) = (n * ceil(2^(N+l) / d)) >> (N+l), l = ceil(log2 d), n < 2^N
	localparam int          RCP_SH   = NUM_W + $clog2(DIVISOR);
	localparam int          RCP_W    = NUM_W + 1;
	localparam int          PROD_W   = NUM_W + RCP_W;
	localparam logic [63:0] RCP_POW  = 64'd1 << RCP_SH;
	localparam logic [63:0] RCP_FULL = (RCP_POW + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
	localparam logic [RCP_W-1:0] RCP = RCP_W'(RCP_FULL);

	logic [PROD_W-1:0] prod_q;
	logic              done_q;

	assign done = done_q;
	assign quot = NUM_W'(prod_q >> RCP_SH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= start;
		end
	end

	// product by the reciprocal, taken on start
	always_ff @(posedge clk) begin
		if (start) prod_q <= PROD_W'(numer) * PROD_W'(RCP);
	end

endmodule

`default_nettype wire

>>> hdl/sliding_trimmed_mean_filter_core.sv
// ----------------------------------------------------------------------------
// sliding_trimmed_mean_filter_core
// Interquartile mean of the last WINDOW_LEN pressure samples.
// ----------------------------------------------------------------------------
// Each request writes one 24-bit sample into a window that starts all zero
// and gives one result: the mean of the middle half of the ordered window,
// the lowest and highest WINDOW_LEN/4 entries left out, as an unsigned value
// with 4 fraction bits, truncated. The window is kept in order by a chain of
// cells that drops the oldest entry and inserts the new one in the cycle the
// request is taken. The kept entries are then summed one per cycle
// (WINDOW_LEN/2 rounded down to even) and the sum divided by a multiply with
// the reciprocal of the divisor. Requests are taken one at a time: no new
// request is taken until the result of the last one has been loaded into
// the result register; a result that is still waiting when the next one is
// ready holds the block until it is taken. The result register lets a new
// request in while the previous result still waits.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_trimmed_mean_filter_core #(
	parameter int WINDOW_LEN = stmf_pkg::WINDOW_LEN_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           sample_valid,
	output logic                                sample_ready,
	input  wire logic [stmf_pkg::SAMPLE_W-1:0]  pressure_sample,
	output logic                                result_valid,
	input  wire logic                           result_ready,
	output logic      [stmf_pkg::OUT_W-1:0]     filtered_pressure
);

	localparam int VAL_W   = stmf_pkg::SAMPLE_W;
	localparam int QUARTER = WINDOW_LEN / 4;
	localparam int MID_CNT = 2 * QUARTER;
	localparam int IDX_W   = $clog2(WINDOW_LEN);
	localparam int AGE_W   = IDX_W;
	localparam int SUM_W   = VAL_W + $clog2(MID_CNT);
	localparam int SHIFT   = stmf_pkg::FRAC_W - 1;
	localparam int NUM_W   = SUM_W + SHIFT;
	localparam logic [IDX_W-1:0] FIRST = IDX_W'(QUARTER);
	localparam logic [IDX_W-1:0] LAST  = IDX_W'(3 * QUARTER - 1);

	stmf_pkg::stmf_state_t state_q, state_nxt;

	logic             accept;
	logic             out_free;
	logic             out_load;
	logic             div_start;
	logic             div_done;
	logic [NUM_W-1:0] div_quot;
	logic [NUM_W-1:0] div_numer;

	logic [IDX_W-1:0] idx_q;
	logic [SUM_W-1:0] acc_q;
	logic             result_valid_q;
	logic [stmf_pkg::OUT_W-1:0] result_q;

	// padded links: slot 0 and slot WINDOW_LEN+1 are the chain ends
	logic [VAL_W-1:0] link_val [0:WINDOW_LEN+1];
	logic [AGE_W-1:0] link_age [0:WINDOW_LEN+1];
	logic             link_gt  [0:WINDOW_LEN+1];
	logic             below    [0:WINDOW_LEN];
	logic [VAL_W-1:0] cell_val [0:WINDOW_LEN-1];

	assign accept = sample_valid && sample_ready;

	// chain ends: nothing below the first cell, infinity above the last
	assign link_val[0]            = '0;
	assign link_age[0]            = '0;
	assign link_gt[0]             = 1'b0;
	assign link_val[WINDOW_LEN+1] = '0;
	assign link_age[WINDOW_LEN+1] = '0;
	assign link_gt[WINDOW_LEN+1]  = 1'b1;
	assign below[0]               = 1'b0;

	// sorted window, smallest in cell 0
	for (genvar i = 0; i < WINDOW_LEN; i++) begin : g_cell
		stmf_cell #(
			.VAL_W     (VAL_W),
			.AGE_W     (AGE_W),
			.OLDEST    (WINDOW_LEN - 1),
			.RESET_AGE (WINDOW_LEN - 1 - i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.load      (accept),
			.sample    (pressure_sample),
			.left_val  (link_val[i]),
			.left_age  (link_age[i]),
			.left_gt   (link_gt[i]),
			.right_val (link_val[i+2]),
			.right_age (link_age[i+2]),
			.right_gt  (link_gt[i+2]),
			.below_in  (below[i]),
			.below_out (below[i+1]),
			.val       (link_val[i+1]),
			.age       (link_age[i+1]),
			.gt        (link_gt[i+1])
		);
		assign cell_val[i] = link_val[i+1];
	end

	// mean = floor(16 * sum / MID_CNT) = floor(8 * sum / QUARTER)
	assign div_numer = {acc_q, SHIFT'(0)};

	stmf_divider #(
		.NUM_W   (NUM_W),
		.DIVISOR (QUARTER)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.numer  (div_numer),
		.done   (div_done),
		.quot   (div_quot)
	);

	assign out_free = !result_valid_q || result_ready;

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			stmf_pkg::ST_IDLE: begin
				if (sample_valid) state_nxt = stmf_pkg::ST_SUM;
			end
			stmf_pkg::ST_SUM: begin
				if (idx_q == LAST) state_nxt = stmf_pkg::ST_LAUNCH;
			end
			stmf_pkg::ST_LAUNCH: begin
				state_nxt = stmf_pkg::ST_DIV;
			end
			stmf_pkg::ST_DIV: begin
				if (div_done) state_nxt = out_free ? stmf_pkg::ST_IDLE : stmf_pkg::ST_HOLD;
			end
			stmf_pkg::ST_HOLD: begin
				if (out_free) state_nxt = stmf_pkg::ST_IDLE;
			end
			default: state_nxt = stmf_pkg::ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		sample_ready = 1'b0;
		div_start    = 1'b0;
		out_load     = 1'b0;
		unique case (state_q)
			stmf_pkg::ST_IDLE:   sample_ready = 1'b1;
			stmf_pkg::ST_SUM:    ;
			stmf_pkg::ST_LAUNCH: div_start = 1'b1;
			stmf_pkg::ST_DIV:    out_load = div_done && out_free;
			stmf_pkg::ST_HOLD:   out_load = out_free;
			default:             ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= stmf_pkg::ST_IDLE;
			idx_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (accept) begin
				idx_q <= FIRST;
			end else if (state_q == stmf_pkg::ST_SUM) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			if (out_load) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// middle-slice sum, one cell per cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			acc_q <= '0;
		end else if (state_q == stmf_pkg::ST_SUM) begin
			acc_q <= acc_q + SUM_W'(cell_val[idx_q]);
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (out_load) result_q <= div_quot[stmf_pkg::OUT_W-1:0];
	end

	assign result_valid      = result_valid_q;
	assign filtered_pressure = result_q;

endmodule

`default_nettype wire

>>> hdl/stmf_checker.sv
// ----------------------------------------------------------------------------
// stmf_checker
// Port-level checks of the sliding trimmed mean filter, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sliding_trimmed_mean_filter_core_assert.svh"

module stmf_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       sample_valid,
	input wire logic                       sample_ready,
	input wire logic                       result_valid,
	input wire logic                       result_ready,
	input wire logic [stmf_pkg::OUT_W-1:0] filtered_pressure
);

	// a waiting result holds its value
	`STMF_ASSERT_NXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(filtered_pressure), "result dropped or changed while stalled")

	// one request at a time: no new request right after one is taken
	`STMF_ASSERT_NXT(a_one_in_flight, sample_valid && sample_ready, !sample_ready, "request taken while previous still in work")

	// a fresh result only comes out of a busy phase
	`STMF_ASSERT_IMP(a_result_from_work, $rose(result_valid), $past(!sample_ready), "result appeared without work behind it")

	// the mean never exceeds a full-scale sample
	`STMF_ASSERT_IMP(a_result_range, result_valid, filtered_pressure <= stmf_pkg::OUT_MAX, "mean beyond full scale")

endmodule

bind sliding_trimmed_mean_filter_core stmf_checker u_stmf_checker (.*);

`default_nettype wire
